// ----- rtl/core/ats_pkg.sv -----
package ats_pkg;

  localparam int LINES_DEF     = 8;
  localparam int TAG_BITS_DEF  = 16;
  localparam int COST_BITS_DEF = 16;

  localparam int MODE_W   = 2;
  localparam int TAG_W    = 16;
  localparam int SLOT_W   = 3;
  localparam int INDEX_W  = 3;

  typedef enum logic [MODE_W-1:0] {
    MODE_LOOKUP = 2'd0,
    MODE_INSERT = 2'd1,
    MODE_INVAL  = 2'd2,
    MODE_RSVD   = 2'd3
  } mode_t;

  localparam logic POLICY_LRU = 1'b0;
  localparam logic POLICY_LFU = 1'b1;

  typedef struct packed {
    logic load;
    logic scan;
    logic sweep;
    logic decide;
  } cmd_t;

  typedef struct packed {
    logic last_data;
    logic need_sweep;
  } status_t;

endpackage

// ----- rtl/core/ats_ram.sv -----
module ats_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/core/ats_ctrl.sv -----
module ats_ctrl (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [ats_pkg::MODE_W-1:0]     in_mode,
  input  ats_pkg::status_t               status,
  output ats_pkg::cmd_t                  cmd,
  output logic                           busy
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SCAN   = 4'b0010,
    S_DECIDE = 4'b0100,
    S_SWEEP  = 4'b1000
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   needs_scan;

  assign needs_scan = (ats_pkg::mode_t'(in_mode) == ats_pkg::MODE_LOOKUP) ||
                      (ats_pkg::mode_t'(in_mode) == ats_pkg::MODE_INSERT);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = needs_scan ? S_SCAN : S_DECIDE;
        end
      end
      S_SCAN: begin
        if (status.last_data) begin
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        state_nxt = status.need_sweep ? S_SWEEP : S_IDLE;
      end
      S_SWEEP: begin
        if (status.last_data) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy       = (state_r != S_IDLE);
  assign cmd.load   = (state_r == S_IDLE) && start;
  assign cmd.scan   = (state_r == S_SCAN);
  assign cmd.sweep  = (state_r == S_SWEEP);
  assign cmd.decide = (state_r == S_DECIDE);

endmodule

// ----- rtl/core/ats_dp.sv -----
module ats_dp #(
  parameter int LINES     = ats_pkg::LINES_DEF,
  parameter int TAG_BITS  = ats_pkg::TAG_BITS_DEF,
  parameter int COST_BITS = ats_pkg::COST_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  ats_pkg::cmd_t                   cmd,
  output ats_pkg::status_t                status,
  input  logic [ats_pkg::MODE_W-1:0]      in_mode,
  input  logic [ats_pkg::TAG_W-1:0]       in_tag,
  input  logic [ats_pkg::SLOT_W-1:0]      in_slot,
  input  logic                            cfg_we,
  input  logic                            cfg_wdata,
  output logic                            out_valid,
  output logic                            out_hit,
  output logic [ats_pkg::INDEX_W-1:0]     out_line_index,
  output logic                            out_victim_valid,
  output logic [ats_pkg::TAG_W-1:0]       out_victim_tag
);

  localparam int IDX_W = $clog2(LINES);
  localparam int CNT_W = IDX_W + 1;

  logic                 policy_r;
  logic [LINES-1:0]     valid_r;
  ats_pkg::mode_t       mode_r;
  logic [TAG_BITS-1:0]  tag_r;
  logic [ats_pkg::SLOT_W-1:0] slot_r;

  logic [CNT_W-1:0]     cnt_r;
  logic                 rd_vld_r;
  logic [IDX_W-1:0]     rd_idx_r;

  logic                 match_found_r;
  logic [IDX_W-1:0]     match_idx_r;
  logic                 inv_found_r;
  logic [IDX_W-1:0]     inv_idx_r;
  logic [IDX_W-1:0]     best_idx_r;
  logic [COST_BITS-1:0] best_cost_r;
  logic [TAG_BITS-1:0]  best_tag_r;
  logic [IDX_W-1:0]     touch_idx_r;
  logic                 ins_r;

  logic                 out_valid_r;
  logic                 out_hit_r;
  logic [ats_pkg::INDEX_W-1:0] out_line_index_r;
  logic                 out_victim_valid_r;
  logic [ats_pkg::TAG_W-1:0]   out_victim_tag_r;

  logic                 issue;
  logic [IDX_W-1:0]     rd_addr;
  logic [TAG_BITS-1:0]  tag_rdata;
  logic [COST_BITS-1:0] cost_rdata;
  logic [COST_BITS-1:0] cost_inc;
  logic                 better;
  logic                 is_touch;
  logic                 cost_we;
  logic [COST_BITS-1:0] cost_wdata;
  logic                 tag_we;

  logic [IDX_W-1:0]     ins_idx;
  logic [IDX_W-1:0]     slot_idx;
  logic                 slot_ok;
  logic                 dec_hit;
  logic [IDX_W-1:0]     dec_idx;
  logic                 dec_vvalid;
  logic [TAG_BITS-1:0]  dec_vtag;

  assign issue   = (cmd.scan || cmd.sweep) && (cnt_r < CNT_W'(LINES));
  assign rd_addr = cnt_r[IDX_W-1:0];

  ats_ram #(.WIDTH(TAG_BITS), .DEPTH(LINES)) u_tag_ram (
    .clk   (clk),
    .we    (tag_we),
    .waddr (ins_idx),
    .wdata (tag_r),
    .raddr (rd_addr),
    .rdata (tag_rdata)
  );

  ats_ram #(.WIDTH(COST_BITS), .DEPTH(LINES)) u_cost_ram (
    .clk   (clk),
    .we    (cost_we),
    .waddr (rd_idx_r),
    .wdata (cost_wdata),
    .raddr (rd_addr),
    .rdata (cost_rdata)
  );

  assign cost_inc = (cost_rdata == {COST_BITS{1'b1}}) ? cost_rdata
                                                       : cost_rdata + COST_BITS'(1);
  assign better   = (rd_idx_r == '0) ||
                    ((policy_r == ats_pkg::POLICY_LRU) ? (cost_rdata > best_cost_r)
                                                      : (cost_rdata < best_cost_r));
  assign is_touch = (rd_idx_r == touch_idx_r);
  assign cost_we  = rd_vld_r && cmd.sweep &&
                    (is_touch || ((policy_r == ats_pkg::POLICY_LRU) && valid_r[rd_idx_r]));

  always_comb begin
    if (is_touch) begin
      if (policy_r == ats_pkg::POLICY_LRU) begin
        cost_wdata = '0;
      end else if (ins_r) begin
        cost_wdata = COST_BITS'(1);
      end else begin
        cost_wdata = cost_inc;
      end
    end else begin
      cost_wdata = cost_inc;
    end
  end

  assign ins_idx  = inv_found_r ? inv_idx_r : best_idx_r;
  assign slot_idx = IDX_W'(slot_r);
  assign slot_ok  = (32'(slot_r) < 32'(LINES));
  assign tag_we   = cmd.decide && (mode_r == ats_pkg::MODE_INSERT);

  always_comb begin
    dec_hit    = 1'b0;
    dec_idx    = '0;
    dec_vvalid = 1'b0;
    dec_vtag   = '0;
    unique case (mode_r)
      ats_pkg::MODE_LOOKUP: begin
        dec_hit = match_found_r;
        if (match_found_r) begin
          dec_idx = match_idx_r;
        end
      end
      ats_pkg::MODE_INSERT: begin
        dec_idx    = ins_idx;
        dec_vvalid = !inv_found_r;
        if (!inv_found_r) begin
          dec_vtag = best_tag_r;
        end
      end
      ats_pkg::MODE_INVAL: begin
      end
      ats_pkg::MODE_RSVD: begin
      end
    endcase
  end

  assign status.last_data  = rd_vld_r && (rd_idx_r == IDX_W'(LINES - 1));
  assign status.need_sweep = (mode_r == ats_pkg::MODE_INSERT) ||
                             ((mode_r == ats_pkg::MODE_LOOKUP) && match_found_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      policy_r    <= ats_pkg::POLICY_LRU;
      valid_r     <= '0;
      cnt_r       <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        policy_r <= cfg_wdata;
      end
      if (cmd.load || cmd.decide) begin
        cnt_r <= '0;
      end else if (issue) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end
      rd_vld_r    <= issue;
      out_valid_r <= cmd.decide;
      if (cmd.decide) begin
        if (mode_r == ats_pkg::MODE_INSERT) begin
          valid_r[ins_idx] <= 1'b1;
        end else if ((mode_r == ats_pkg::MODE_INVAL) && slot_ok) begin
          valid_r[slot_idx] <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r <= rd_addr;
    if (cmd.load) begin
      mode_r        <= ats_pkg::mode_t'(in_mode);
      tag_r         <= TAG_BITS'(in_tag);
      slot_r        <= in_slot;
      match_found_r <= 1'b0;
      inv_found_r   <= 1'b0;
    end else if (rd_vld_r && cmd.scan) begin
      if (!match_found_r && valid_r[rd_idx_r] && (tag_rdata == tag_r)) begin
        match_found_r <= 1'b1;
        match_idx_r   <= rd_idx_r;
      end
      if (!inv_found_r && !valid_r[rd_idx_r]) begin
        inv_found_r <= 1'b1;
        inv_idx_r   <= rd_idx_r;
      end
      if (better) begin
        best_idx_r  <= rd_idx_r;
        best_cost_r <= cost_rdata;
        best_tag_r  <= tag_rdata;
      end
    end
    if (cmd.decide) begin
      touch_idx_r        <= dec_idx;
      ins_r              <= (mode_r == ats_pkg::MODE_INSERT);
      out_hit_r          <= dec_hit;
      out_line_index_r   <= ats_pkg::INDEX_W'(dec_idx);
      out_victim_valid_r <= dec_vvalid;
      out_victim_tag_r   <= ats_pkg::TAG_W'(dec_vtag);
    end
  end

  assign out_valid        = out_valid_r;
  assign out_hit          = out_hit_r;
  assign out_line_index   = out_line_index_r;
  assign out_victim_valid = out_victim_valid_r;
  assign out_victim_tag   = out_victim_tag_r;

endmodule

// ----- rtl/core/assoc_tag_store_lru_lfu_top.sv -----
// Lookup and insert scan every line once through the tag and cost RAM read port: the result
// word strobes once the scan and decide state end; a hit or insert then sweeps the cost RAM
// before busy drops, while a lookup miss returns to idle with no sweep.
// Invalidate and the unused mode skip the scan and strobe their word after the decide state.
// Synchronous active-low reset clears all valid bits, selects LRU and empties the pipeline.
// The result word is shown for exactly one cycle; the receiver cannot stall.
module assoc_tag_store_lru_lfu_top #(
  parameter int LINES     = ats_pkg::LINES_DEF,
  parameter int TAG_BITS  = ats_pkg::TAG_BITS_DEF,
  parameter int COST_BITS = ats_pkg::COST_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [ats_pkg::MODE_W-1:0]  in_mode,
  input  logic [ats_pkg::TAG_W-1:0]   in_tag,
  input  logic [ats_pkg::SLOT_W-1:0]  in_slot,
  input  logic                        cfg_we,
  input  logic                        cfg_wdata,
  output logic                        out_valid,
  output logic                        out_hit,
  output logic [ats_pkg::INDEX_W-1:0] out_line_index,
  output logic                        out_victim_valid,
  output logic [ats_pkg::TAG_W-1:0]   out_victim_tag
);

  ats_pkg::cmd_t    cmd;
  ats_pkg::status_t status;

  ats_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_mode (in_mode),
    .status  (status),
    .cmd     (cmd),
    .busy    (busy)
  );

  ats_dp #(
    .LINES     (LINES),
    .TAG_BITS  (TAG_BITS),
    .COST_BITS (COST_BITS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .status           (status),
    .in_mode          (in_mode),
    .in_tag           (in_tag),
    .in_slot          (in_slot),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .out_valid        (out_valid),
    .out_hit          (out_hit),
    .out_line_index   (out_line_index),
    .out_victim_valid (out_victim_valid),
    .out_victim_tag   (out_victim_tag)
  );

endmodule

// ----- rtl/core/ats_chk.sv -----
module ats_chk (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        start,
  input logic                        busy,
  input logic [ats_pkg::MODE_W-1:0]  in_mode,
  input logic                        out_valid,
  input logic                        out_hit,
  input logic                        out_victim_valid,
  input logic [ats_pkg::TAG_W-1:0]   out_victim_tag
);

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy not raised after an accepted word");

  a_no_back_to_back: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for two cycles");

  a_hit_no_victim: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_hit) |-> !out_victim_valid)
    else $error("lookup hit reported a victim");

  a_victim_tag_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_victim_valid) |-> (out_victim_tag == '0))
    else $error("victim tag nonzero without a victim");

  a_inval_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (ats_pkg::mode_t'(in_mode) == ats_pkg::MODE_INVAL)) |-> ##2 out_valid)
    else $error("invalidate result not strobed two cycles after start");

endmodule

bind assoc_tag_store_lru_lfu_top ats_chk u_ats_chk (
  .clk              (clk),
  .rst_n            (rst_n),
  .start            (start),
  .busy             (busy),
  .in_mode          (in_mode),
  .out_valid        (out_valid),
  .out_hit          (out_hit),
  .out_victim_valid (out_victim_valid),
  .out_victim_tag   (out_victim_tag)
);
